// ===== rtl/tdp_pkg.sv =====
`timescale 1ns / 1ps

package tdp_pkg;

    // Width of the candidate port and default width of the arithmetic
    localparam int CAND_WIDTH    = 32;
    localparam int NUM_WIDTH_DEF = 32;

    // Program counter of the sequencer
    localparam int PC_WIDTH = 4;
    typedef logic [PC_WIDTH-1:0] pc_t;

    // Step addresses of the microprogram
    localparam pc_t STEP_IDLE      = 4'd0;
    localparam pc_t STEP_CHK_TWO   = 4'd1;
    localparam pc_t STEP_CHK_EVEN  = 4'd2;
    localparam pc_t STEP_DIV_START = 4'd3;
    localparam pc_t STEP_DIV_LOOP  = 4'd4;
    localparam pc_t STEP_CHK_BOUND = 4'd5;
    localparam pc_t STEP_CHK_REM   = 4'd6;
    localparam pc_t STEP_NEXT_D    = 4'd7;
    localparam pc_t STEP_PASS      = 4'd8;
    localparam pc_t STEP_FAIL      = 4'd9;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_INIT_D,
        UOP_DIV_START,
        UOP_DIV_STEP,
        UOP_D_ADD2,
        UOP_EMIT_ONE,
        UOP_EMIT_ZERO
    } uop_t;

    // Jump condition of one step
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_START,
        COND_IS_TWO,
        COND_NOT_ODD,
        COND_DIV_MORE,
        COND_D_GT_Q,
        COND_REM_ZERO
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        pc_t   target;
    } ucode_word_t;

    // Flags from the datapath to the sequencer
    typedef struct packed {
        logic is_two;
        logic not_odd;
        logic div_more;
        logic d_gt_q;
        logic rem_zero;
    } dp_status_t;

    // Microprogram ROM
    function automatic ucode_word_t ucode_rom(input pc_t pc);
        ucode_word_t w;
        case (pc)
            STEP_IDLE:      w = '{UOP_LOAD,      COND_NOT_START, STEP_IDLE};
            STEP_CHK_TWO:   w = '{UOP_NOP,       COND_IS_TWO,    STEP_PASS};
            STEP_CHK_EVEN:  w = '{UOP_INIT_D,    COND_NOT_ODD,   STEP_FAIL};
            STEP_DIV_START: w = '{UOP_DIV_START, COND_NEVER,     STEP_IDLE};
            STEP_DIV_LOOP:  w = '{UOP_DIV_STEP,  COND_DIV_MORE,  STEP_DIV_LOOP};
            STEP_CHK_BOUND: w = '{UOP_NOP,       COND_D_GT_Q,    STEP_PASS};
            STEP_CHK_REM:   w = '{UOP_NOP,       COND_REM_ZERO,  STEP_FAIL};
            STEP_NEXT_D:    w = '{UOP_D_ADD2,    COND_ALWAYS,    STEP_DIV_START};
            STEP_PASS:      w = '{UOP_EMIT_ONE,  COND_ALWAYS,    STEP_IDLE};
            STEP_FAIL:      w = '{UOP_EMIT_ZERO, COND_ALWAYS,    STEP_IDLE};
            default:        w = '{UOP_NOP,       COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/trial_division_prime_test.sv =====
`timescale 1ns / 1ps
// Channel   Handshake          Ports
// input     start & !busy      candidate[31:0]
// result    done (one cycle)   is_prime
//
// Two is passed, and zero, one and even values are rejected, without any
// division. For other values each odd trial divisor tried costs one pass of
// the bit-serial restoring divider, one quotient bit per cycle. Worst case for
// 32 bits is 32768 divisors.
// Reset is asynchronous; the block is idle straight after it.
// The result strobe cannot be held off; a new item may start in the cycle
// its predecessor's result is shown.

module trial_division_prime_test #(
    parameter int NUM_WIDTH = tdp_pkg::NUM_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tdp_pkg::CAND_WIDTH-1:0] candidate,
    output logic                           done,
    output logic                           is_prime
);
    import tdp_pkg::*;

    uop_t       uop;
    dp_status_t status;

    // Microprogram sequencer
    tdp_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .uop    (uop),
        .busy   (busy)
    );

    // Operand registers and shared divider
    tdp_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop       (uop),
        .candidate (candidate),
        .status    (status),
        .done      (done),
        .is_prime  (is_prime)
    );

    // A result only follows work on an item
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in progress");

    // An accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but sequencer stayed idle");

    // One result per item: the strobe never stays high
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

// ===== rtl/tdp_sequencer.sv =====
`timescale 1ns / 1ps

module tdp_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tdp_pkg::dp_status_t status,
    output tdp_pkg::uop_t       uop,
    output logic                busy
);
    import tdp_pkg::*;

    pc_t         pc_reg;
    pc_t         pc_next;
    ucode_word_t word;
    logic        taken;

    // Control word of the current step
    assign word = ucode_rom(pc_reg);
    assign uop  = word.uop;
    assign busy = (pc_reg != STEP_IDLE);

    // Jump condition
    always_comb
    begin
        case (word.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_NOT_START: taken = !start;
            COND_IS_TWO:    taken = status.is_two;
            COND_NOT_ODD:   taken = status.not_odd;
            COND_DIV_MORE:  taken = status.div_more;
            COND_D_GT_Q:    taken = status.d_gt_q;
            COND_REM_ZERO:  taken = status.rem_zero;
            default:        taken = 1'b1;
        endcase
        pc_next = taken ? word.target : pc_t'(pc_reg + pc_t'(1));
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/tdp_datapath.sv =====
`timescale 1ns / 1ps

module tdp_datapath #(
    parameter int NUM_WIDTH = tdp_pkg::NUM_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tdp_pkg::uop_t                      uop,
    input  logic [tdp_pkg::CAND_WIDTH-1:0]     candidate,
    output tdp_pkg::dp_status_t                status,
    output logic                               done,
    output logic                               is_prime
);
    import tdp_pkg::*;

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] n_reg,    n_next;
    logic [NUM_WIDTH-1:0] d_reg,    d_next;
    logic [NUM_WIDTH-1:0] rem_reg,  rem_next;
    logic [NUM_WIDTH-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 done_reg, done_next;
    logic                 prime_reg, prime_next;

    logic [NUM_WIDTH:0]   trial;
    logic [NUM_WIDTH:0]   diff;
    logic                 ge;

    // One restoring division step: bring down the next dividend bit
    assign trial = {rem_reg, quot_reg[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    // Next values per micro-operation
    always_comb
    begin
        n_next     = n_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        case (uop)
            UOP_NOP:
            begin
            end
            UOP_LOAD:
            begin
                n_next = NUM_WIDTH'(candidate);
            end
            UOP_INIT_D:
            begin
                d_next = NUM_WIDTH'(3);
            end
            UOP_DIV_START:
            begin
                rem_next  = '0;
                quot_next = n_reg;
                cnt_next  = CNT_W'(NUM_WIDTH);
            end
            UOP_DIV_STEP:
            begin
                rem_next  = ge ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
                quot_next = {quot_reg[NUM_WIDTH-2:0], ge};
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            UOP_D_ADD2:
            begin
                d_next = d_reg + NUM_WIDTH'(2);
            end
            UOP_EMIT_ONE:
            begin
                done_next  = 1'b1;
                prime_next = 1'b1;
            end
            UOP_EMIT_ZERO:
            begin
                done_next  = 1'b1;
                prime_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Flags for the sequencer
    assign status.is_two   = (n_reg == NUM_WIDTH'(2));
    assign status.not_odd  = (n_reg < NUM_WIDTH'(2)) || !n_reg[0];
    assign status.div_more = (cnt_reg != CNT_W'(1));
    assign status.d_gt_q   = (d_reg > quot_reg);
    assign status.rem_zero = (rem_reg == '0);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        prime_reg <= prime_next;
    end

    assign done     = done_reg;
    assign is_prime = prime_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import tdp_pkg::*;

    localparam int NUM_W       = NUM_WIDTH_DEF;
    localparam int RAND_ITEMS  = 78;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int N_PROBES    = 22;

    // One directed row: candidate, and a typed-in verdict where it is obvious
    typedef struct packed {
        logic [CAND_WIDTH-1:0] value;
        logic                  typed;
        logic                  verdict;
    } probe_t;

    // Verdict still owed by the block
    typedef struct packed {
        logic [CAND_WIDTH-1:0] value;
        logic                  prime;
    } verdict_t;

    localparam probe_t PROBES [0:N_PROBES-1] = '{
        '{32'd0,          1'b1, 1'b0},
        '{32'd1,          1'b1, 1'b0},
        '{32'd2,          1'b1, 1'b1},
        '{32'd3,          1'b0, 1'b0},
        '{32'd4,          1'b1, 1'b0},
        '{32'd5,          1'b0, 1'b0},
        '{32'd9,          1'b0, 1'b0},
        '{32'd15,         1'b0, 1'b0},
        '{32'd25,         1'b0, 1'b0},
        '{32'd49,         1'b0, 1'b0},
        '{32'd121,        1'b0, 1'b0},
        '{32'd65535,      1'b0, 1'b0},
        '{32'd65521,      1'b0, 1'b0},
        '{32'd65537,      1'b0, 1'b0},
        '{32'd16777213,   1'b0, 1'b0},
        '{32'd16752649,   1'b0, 1'b0},
        '{32'h5555_5555,  1'b0, 1'b0},
        '{32'hAAAA_AAAB,  1'b0, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},
        '{32'h8000_0001,  1'b0, 1'b0},
        '{32'hFFFF_FFFE,  1'b1, 1'b0},
        '{32'hFFFF_FFFF,  1'b0, 1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [CAND_WIDTH-1:0] candidate;
    logic                  done;
    logic                  is_prime;

    verdict_t pending_verdicts [$];
    verdict_t head;
    int       mismatches;
    int       cycles;
    int       burst_left;

    trial_division_prime_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .candidate (candidate),
        .done      (done),
        .is_prime  (is_prime)
    );

    always #5 clk = ~clk;

    // Trial division over the low NUM_W bits, square bound kept at 64 bits
    function automatic logic prime_flag(input logic [CAND_WIDTH-1:0] value);
        logic [63:0] mask;
        logic [63:0] n;
        logic [63:0] d;
        mask = (NUM_W >= 64) ? '1 : ((64'd1 << NUM_W) - 64'd1);
        n = {32'd0, value} & mask;
        if (n < 64'd2)
            return 1'b0;
        if (n == 64'd2)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = 64'd3; d <= n / d; d = d + 64'd2)
        begin
            if (n % d == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Random candidate: mostly cheap to test, all bits exercised
    function automatic logic [CAND_WIDTH-1:0] draw_candidate();
        int unsigned           sel;
        logic [CAND_WIDTH-1:0] r;
        int unsigned           p;
        int unsigned           factors [8];
        factors = '{3, 5, 7, 11, 13, 17, 19, 23};
        sel = $urandom_range(0, 99);
        r   = $urandom;
        if (sel < 40)
            return $urandom_range(0, 4095);
        else if (sel < 55)
            return {r[CAND_WIDTH-1:1], 1'b0};
        else if (sel < 88)
        begin
            // large multiple of a small odd factor: rejected after few divisors
            p = factors[$urandom_range(0, 7)];
            return r - (r % p);
        end
        else
            return $urandom_range(0, 20'hFFFFF);
    endfunction

    // Present one item at a falling edge, hold it until accepted
    task automatic offer(input logic [CAND_WIDTH-1:0] value, input logic typed,
                         input logic verdict);
        verdict_t v;
        v.value = value;
        v.prime = typed ? verdict : prime_flag(value);
        start     <= 1'b1;
        candidate <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_verdicts.push_back(v);
        @(negedge clk);
    endtask

    // Hold the sender off until every owed verdict has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // Bursts of items separated by random gaps; sometimes wait for the block to drain
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        if ($urandom_range(0, 7) == 0)
            drain_results();
        else
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
                                                 : $urandom_range(0, 6);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                if (mismatches < 10)
                    $display("tb: result with none owed, is_prime=%0b", is_prime);
                mismatches++;
            end
            else
            begin
                head = pending_verdicts.pop_front();
                if (is_prime !== head.prime)
                begin
                    if (mismatches < 10)
                        $display("tb: candidate %0d expected is_prime=%0b got %0b",
                                 head.value, head.prime, is_prime);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        candidate  = '0;
        mismatches = 0;
        cycles     = 0;
        burst_left = 3;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows
        for (int i = 0; i < N_PROBES; i++)
        begin
            offer(PROBES[i].value, PROBES[i].typed, PROBES[i].verdict);
            pace_sender();
        end
        drain_results();

        // random items
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            offer(draw_candidate(), 1'b0, 1'b0);
            pace_sender();
        end
        start <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tdp_pkg.sv
rtl/tdp_sequencer.sv
rtl/tdp_datapath.sv
rtl/trial_division_prime_test.sv
bench/tb.sv
